@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the texture coordinate generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Implication checked at every edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`endif

@@ rtl/texcg_pkg.sv @@
// ----------------------------------------------------------------------------
// texcg_pkg
// Types, register codes and tables of the texture coordinate generator.
// ----------------------------------------------------------------------------
package texcg_pkg;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic               last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [23:0] tex_u;
      logic signed [23:0] tex_v;
      logic               last_out;
   } rsp_type;

   localparam logic [1:0] CSR_MAP_MODE    = 2'd0;
   localparam logic [1:0] CSR_MESH_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_MESH_HEIGHT = 2'd2;

   localparam logic        MODE_PLANAR      = 1'b0;
   localparam logic        MODE_CYLINDRICAL = 1'b1;
   localparam logic [15:0] MESH_RESET       = 16'd256;

   localparam int DIV_BITS   = 32;
   localparam int DIV_LAT    = DIV_BITS + 2;
   localparam int CORDIC_IT  = 16;
   localparam int CORDIC_LAT = CORDIC_IT + 2;
   localparam int PAD_LAT    = DIV_LAT - CORDIC_LAT;
   localparam int TOTAL_LAT  = DIV_LAT + 1;

   localparam logic signed [23:0] HALF_Q16 = 24'sd32768;
   localparam logic signed [25:0] QUARTER_TURN = 26'sd4194304;

   localparam logic signed [25:0] ATAN_TURNS [CORDIC_IT] = '{
      26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050,
      26'sd166669,  26'sd83416,   26'sd41718,  26'sd20860,
      26'sd10430,   26'sd5215,    26'sd2608,   26'sd1304,
      26'sd652,     26'sd326,     26'sd163,    26'sd81
   };

   typedef struct packed {
      logic               valid;
      logic               mode;
      logic               last;
      logic signed [17:0] v_cyl;
   } ctl_type;

endpackage

@@ rtl/texcg_div.sv @@
// ----------------------------------------------------------------------------
// texcg_div
// Pipelined rounded division of a Q8.8 position by a Q8.8 extent, plus 0.5,
// saturated to Q7.16. One quotient bit per stage.
// ----------------------------------------------------------------------------
module texcg_div
   import texcg_pkg::*;
(
   input  logic               clock,
   input  logic signed [15:0] in_p,
   input  logic [15:0]        in_d,
   output logic signed [23:0] out_q
);

   logic [DIV_BITS-1:0] num_ff [DIV_BITS+1];
   logic [DIV_BITS-1:0] quo_ff [DIV_BITS+1];
   logic [15:0]         rem_ff [DIV_BITS+1];
   logic [15:0]         dsr_ff [DIV_BITS+1];
   logic                neg_ff [DIV_BITS+1];
   logic signed [23:0]  out_ff;

   logic [15:0]         mag_in;
   logic [15:0]         dsr_in;
   logic signed [33:0]  qs_in;
   logic signed [33:0]  sum_in;

   always_comb begin
      mag_in = in_p[15] ? 16'(-in_p) : 16'(in_p);
      dsr_in = (in_d == 16'd0) ? 16'd1 : in_d;
   end

   always_ff @(posedge clock) begin
      num_ff[0] <= {mag_in, 16'd0} + {17'd0, dsr_in[15:1]};
      quo_ff[0] <= '0;
      rem_ff[0] <= '0;
      dsr_ff[0] <= dsr_in;
      neg_ff[0] <= in_p[15];
   end

   for (genvar k = 1; k <= DIV_BITS; k++) begin : g_step
      logic [16:0] trial;
      logic        ge;
      always_comb begin
         trial = {rem_ff[k-1], num_ff[k-1][DIV_BITS-1]};
         ge    = trial >= {1'b0, dsr_ff[k-1]};
      end
      always_ff @(posedge clock) begin
         rem_ff[k] <= ge ? 16'(trial - {1'b0, dsr_ff[k-1]}) : trial[15:0];
         num_ff[k] <= {num_ff[k-1][DIV_BITS-2:0], 1'b0};
         quo_ff[k] <= {quo_ff[k-1][DIV_BITS-2:0], ge};
         dsr_ff[k] <= dsr_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
   end

   always_comb begin
      qs_in  = neg_ff[DIV_BITS] ? -$signed({2'b00, quo_ff[DIV_BITS]})
                                :  $signed({2'b00, quo_ff[DIV_BITS]});
      sum_in = qs_in + 34'(HALF_Q16);
   end

   always_ff @(posedge clock) begin
      if (sum_in > 34'sd8388607) begin
         out_ff <= 24'sd8388607;
      end else if (sum_in < -34'sd8388608) begin
         out_ff <= -24'sd8388608;
      end else begin
         out_ff <= sum_in[23:0];
      end
   end

   assign out_q = out_ff;

endmodule

@@ rtl/texcg_cordic.sv @@
// ----------------------------------------------------------------------------
// texcg_cordic
// Pipelined vectoring CORDIC for atan2(nz, nx) in turns, offset by 0.5 and
// rounded to Q7.16. One iteration per stage.
// ----------------------------------------------------------------------------
module texcg_cordic
   import texcg_pkg::*;
(
   input  logic               clock,
   input  logic signed [15:0] in_nx,
   input  logic signed [15:0] in_nz,
   output logic signed [23:0] out_u
);

   logic signed [26:0] x_ff    [CORDIC_IT+1];
   logic signed [26:0] y_ff    [CORDIC_IT+1];
   logic signed [25:0] z_ff    [CORDIC_IT+1];
   logic               zero_ff [CORDIC_IT+1];
   logic signed [23:0] out_ff;

   logic signed [26:0] xs_in;
   logic signed [26:0] ys_in;
   logic signed [25:0] zr_in;
   logic signed [17:0] ang_in;

   always_comb begin
      xs_in = 27'(in_nx) <<< 8;
      ys_in = 27'(in_nz) <<< 8;
   end

   always_ff @(posedge clock) begin
      zero_ff[0] <= (in_nx == 16'sd0) && (in_nz == 16'sd0);
      if (xs_in < 0) begin
         if (ys_in >= 0) begin
            x_ff[0] <= ys_in;
            y_ff[0] <= -xs_in;
            z_ff[0] <= QUARTER_TURN;
         end else begin
            x_ff[0] <= -ys_in;
            y_ff[0] <= xs_in;
            z_ff[0] <= -QUARTER_TURN;
         end
      end else begin
         x_ff[0] <= xs_in;
         y_ff[0] <= ys_in;
         z_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= CORDIC_IT; k++) begin : g_iter
      logic signed [26:0] dx;
      logic signed [26:0] dy;
      always_comb begin
         dx = y_ff[k-1] >>> (k - 1);
         dy = x_ff[k-1] >>> (k - 1);
      end
      always_ff @(posedge clock) begin
         zero_ff[k] <= zero_ff[k-1];
         if (y_ff[k-1] > 0) begin
            x_ff[k] <= x_ff[k-1] + dx;
            y_ff[k] <= y_ff[k-1] - dy;
            z_ff[k] <= z_ff[k-1] + ATAN_TURNS[k-1];
         end else begin
            x_ff[k] <= x_ff[k-1] - dx;
            y_ff[k] <= y_ff[k-1] + dy;
            z_ff[k] <= z_ff[k-1] - ATAN_TURNS[k-1];
         end
      end
   end

   always_comb begin
      zr_in  = z_ff[CORDIC_IT] + 26'sd128;
      ang_in = 18'(zr_in >>> 8);
   end

   always_ff @(posedge clock) begin
      if (zero_ff[CORDIC_IT]) begin
         out_ff <= HALF_Q16;
      end else begin
         out_ff <= 24'(ang_in) + HALF_Q16;
      end
   end

   assign out_u = out_ff;

endmodule

@@ rtl/texture_coordinate_generator.sv @@
// ----------------------------------------------------------------------------
// texture_coordinate_generator
// Per-vertex planar or cylindrical texture coordinate generation.
// ----------------------------------------------------------------------------
// One vertex transaction is taken every clock while start is high; busy never
// rises. Each result appears on rsp_data with rsp_valid high for one cycle,
// in order. The latency is set by the planar divider, which resolves one
// quotient bit per stage over 32 stages; the cylindrical CORDIC path (16
// iteration stages) is padded to match. The receiver cannot stall, so
// results must be taken as they come. Change the configuration registers
// only while no transaction is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module texture_coordinate_generator
   import texcg_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  req_type     req_data,
   output logic        rsp_valid,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic               mode_ff;
   logic [15:0]        width_ff;
   logic [15:0]        height_ff;
   ctl_type            ctl_ff [DIV_LAT];
   ctl_type            ctl_in;
   logic signed [23:0] ucyl_ff [PAD_LAT];
   logic               rsp_valid_ff;
   logic               out_mode_ff;
   rsp_type            rsp_data_ff;

   logic signed [23:0] u_plan;
   logic signed [23:0] v_plan;
   logic signed [23:0] u_cyl;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PLANAR;
         width_ff  <= MESH_RESET;
         height_ff <= MESH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAP_MODE:    mode_ff   <= csr_wdata[0];
            CSR_MESH_WIDTH:  width_ff  <= csr_wdata;
            CSR_MESH_HEIGHT: height_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   texcg_div u_div_u (
      .clock (clock),
      .in_p  (req_data.pos_x),
      .in_d  (width_ff),
      .out_q (u_plan)
   );

   texcg_div u_div_v (
      .clock (clock),
      .in_p  (req_data.pos_y),
      .in_d  (height_ff),
      .out_q (v_plan)
   );

   texcg_cordic u_cordic (
      .clock (clock),
      .in_nx (req_data.norm_x),
      .in_nz (req_data.norm_z),
      .out_u (u_cyl)
   );

   always_comb begin
      ctl_in.valid = start && !busy;
      ctl_in.mode  = mode_ff;
      ctl_in.last  = req_data.last_vertex;
      ctl_in.v_cyl = (18'(req_data.norm_y) + 18'sd16384) <<< 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         ctl_ff[0] <= ctl_in;
         for (int i = 1; i < DIV_LAT; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      ucyl_ff[0] <= u_cyl;
      for (int i = 1; i < PAD_LAT; i++) begin
         ucyl_ff[i] <= ucyl_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctl_ff[DIV_LAT-1].valid;
      end
      out_mode_ff          <= ctl_ff[DIV_LAT-1].mode;
      rsp_data_ff.last_out <= ctl_ff[DIV_LAT-1].last;
      if (ctl_ff[DIV_LAT-1].mode == MODE_CYLINDRICAL) begin
         rsp_data_ff.tex_u <= ucyl_ff[PAD_LAT-1];
         rsp_data_ff.tex_v <= 24'(ctl_ff[DIV_LAT-1].v_cyl);
      end else begin
         rsp_data_ff.tex_u <= u_plan;
         rsp_data_ff.tex_v <= v_plan;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_valid, $past(start, TOTAL_LAT))
   `ASSERT_IMPLY(a_cyl_u_range, clock, reset,
      rsp_valid && (out_mode_ff == MODE_CYLINDRICAL),
      (rsp_data.tex_u >= -24'sd65536) && (rsp_data.tex_u <= 24'sd131072))
   `ASSERT_IMPLY(a_cyl_v_range, clock, reset,
      rsp_valid && (out_mode_ff == MODE_CYLINDRICAL),
      (rsp_data.tex_v >= -24'sd32768) && (rsp_data.tex_v <= 24'sd98302))
   `ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)

endmodule
